// File: design/hcrt_pkg.sv
`default_nettype none

package hcrt_pkg;

  localparam int DELAY_BITS_DEF = 40;
  localparam int COUNT_W        = 32;
  localparam int LEVEL_W        = 16;
  localparam int PERIOD_W       = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [LEVEL_W-1:0]  INIT_LEVEL_RST = 16'd5;
  localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST  = 16'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd5;

  // Reciprocal of ten, exact for every 16-bit value after a shift by 19.
  localparam logic [LEVEL_W:0] RECIP10      = 17'd52429;
  localparam int               RECIP10_SHR  = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_LEVEL  = 2'd0,
    REG_MAX_LEVEL      = 2'd1,
    REG_CONTROL_PERIOD = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACCUM,
    ST_TRIM,
    ST_STEP,
    ST_OUT
  } state_e;

  function automatic logic [LEVEL_W-1:0] div10(input logic [LEVEL_W-1:0] x);
    logic [LEVEL_W+RECIP10_SHR-1:0] p;
    p = {{RECIP10_SHR{1'b0}}, x} * {{(RECIP10_SHR-1){1'b0}}, RECIP10};
    return p[RECIP10_SHR +: LEVEL_W];
  endfunction

endpackage

`default_nettype wire

// File: design/hcrt_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module hcrt_divider #(
  parameter int W = hcrt_pkg::DELAY_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [W-1:0]                 dividend_i,
  input  wire logic [hcrt_pkg::COUNT_W-1:0] divisor_i,
  output logic                              done_o,
  output logic [W-1:0]                      quotient_o
);

  localparam int DW = hcrt_pkg::COUNT_W;
  localparam int CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  dq_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, dq_q[W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[W-2:0], fits};
      rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

// File: design/hill_climb_rate_tuner_top.sv
`default_nettype none

// Hill-climbing pause-level tuner. Each input transaction carries one sampling
// period's commit count and summed commit delay; each yields exactly one result
// transaction with the current pause level, a flag set when the sample closed a
// control period, and the average delay (total / count, 0 for a zero count).
// Nonzero samples are accumulated; after control_period of them the largest and
// smallest averages are trimmed from the sum, and the level moves one
// perturb-and-observe step (level/10, at least 1), reversing direction when
// the trimmed total rose and holding when it is unchanged, clamped to
// 0..max_level. A nonzero sample's average comes from the bit-serial divider,
// which resolves one quotient bit per cycle, and is then accumulated; a sample
// that closes a control period also passes the trim and step states before the
// output state. A zero-count sample goes straight from idle to the output
// state. in_stall_o stays high while a transaction is in flight, and longer
// while a finished result waits for a full output register. The result sits
// in an output register until taken. Configuration writes are always ready and
// must only be issued while the block is idle; writing initial_level also loads
// the live level.
module hill_climb_rate_tuner_top #(
  parameter int DELAY_BITS = hcrt_pkg::DELAY_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [hcrt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [hcrt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [hcrt_pkg::COUNT_W-1:0]    commit_count_i,
  input  wire logic [DELAY_BITS-1:0]           commit_total_delay_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [hcrt_pkg::LEVEL_W-1:0]         pause_level_o,
  output logic                                 level_updated_o,
  output logic [DELAY_BITS-1:0]                average_delay_o
);

  localparam int SUM_BITS = DELAY_BITS + 8;
  localparam int LW       = hcrt_pkg::LEVEL_W;
  localparam int PW       = hcrt_pkg::PERIOD_W;

  hcrt_pkg::state_e state_q, state_d;

  // configuration registers
  logic [LW-1:0] max_level_q;
  logic [PW-1:0] control_period_q;

  // tuner state
  logic [PW-1:0]         sample_counter_q;
  logic [SUM_BITS-1:0]   delay_sum_q;
  logic [DELAY_BITS-1:0] largest_q;
  logic [DELAY_BITS-1:0] smallest_q;
  logic [SUM_BITS-1:0]   previous_sum_q;
  logic [LW-1:0]         level_q;
  logic                  dir_up_q;

  // working registers
  logic [DELAY_BITS-1:0] avg_q;
  logic                  updated_q;
  logic [SUM_BITS-1:0]   trimmed_q;
  logic [LW-1:0]         step_q;

  // output register
  logic                  out_valid_q;
  logic [LW-1:0]         out_level_q;
  logic                  out_updated_q;
  logic [DELAY_BITS-1:0] out_avg_q;

  logic                  div_start;
  logic                  div_done;
  logic [DELAY_BITS-1:0] quotient;

  logic in_accept;
  logic cfg_write;
  logic out_take;
  logic load_out;
  logic count_zero;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign count_zero  = (commit_count_i == '0);

  hcrt_divider #(
    .W (DELAY_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (commit_total_delay_i),
    .divisor_i  (commit_count_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // accumulate stage arithmetic
  logic [PW-1:0]       cnt_inc;
  logic                period_done;
  logic [SUM_BITS:0]   sum_ext;
  logic [SUM_BITS-1:0] sum_sat;

  assign cnt_inc     = sample_counter_q + PW'(1);
  assign period_done = (cnt_inc >= control_period_q) || (cnt_inc == '0);
  assign sum_ext     = {1'b0, delay_sum_q} + {{(SUM_BITS+1-DELAY_BITS){1'b0}}, avg_q};
  assign sum_sat     = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];

  // trim stage arithmetic
  logic [SUM_BITS-1:0] cut;
  logic [LW-1:0]       lvl10;

  assign cut   = {{(SUM_BITS-DELAY_BITS){1'b0}}, largest_q}
               + {{(SUM_BITS-DELAY_BITS){1'b0}}, smallest_q};
  assign lvl10 = hcrt_pkg::div10(level_q);

  // step stage arithmetic
  logic          rose;
  logic          same;
  logic          dir_next;
  logic [LW-1:0] step_eff;
  logic [LW:0]   cand;
  logic [LW-1:0] level_next;

  assign rose     = (trimmed_q > previous_sum_q);
  assign same     = (trimmed_q == previous_sum_q);
  assign dir_next = rose ? !dir_up_q : dir_up_q;
  assign step_eff = same ? '0 : step_q;

  always_comb begin
    if (dir_next) begin
      cand = {1'b0, level_q} + {1'b0, step_eff};
    end else if (level_q < step_eff) begin
      cand = '0;
    end else begin
      cand = {1'b0, level_q - step_eff};
    end
    level_next = (cand > {1'b0, max_level_q}) ? max_level_q : cand[LW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hcrt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = count_zero ? hcrt_pkg::ST_OUT : hcrt_pkg::ST_DIV;
        end
      end
      hcrt_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = hcrt_pkg::ST_ACCUM;
        end
      end
      hcrt_pkg::ST_ACCUM: begin
        state_d = period_done ? hcrt_pkg::ST_TRIM : hcrt_pkg::ST_OUT;
      end
      hcrt_pkg::ST_TRIM: state_d = hcrt_pkg::ST_STEP;
      hcrt_pkg::ST_STEP: state_d = hcrt_pkg::ST_OUT;
      hcrt_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = hcrt_pkg::ST_IDLE;
        end
      end
      default: state_d = hcrt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != hcrt_pkg::ST_IDLE);
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      hcrt_pkg::ST_IDLE: div_start = in_valid_i && !count_zero;
      hcrt_pkg::ST_OUT:  load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcrt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration and tuner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q      <= hcrt_pkg::MAX_LEVEL_RST;
      control_period_q <= hcrt_pkg::PERIOD_RST;
      sample_counter_q <= '0;
      delay_sum_q      <= '0;
      largest_q        <= '0;
      smallest_q       <= '1;
      previous_sum_q   <= '1;
      level_q          <= hcrt_pkg::INIT_LEVEL_RST;
      dir_up_q         <= 1'b1;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_i)
          hcrt_pkg::REG_INITIAL_LEVEL:  level_q          <= cfg_data_i[LW-1:0];
          hcrt_pkg::REG_MAX_LEVEL:      max_level_q      <= cfg_data_i[LW-1:0];
          hcrt_pkg::REG_CONTROL_PERIOD: control_period_q <= cfg_data_i[PW-1:0];
          default: ;
        endcase
      end
      if (state_q == hcrt_pkg::ST_ACCUM) begin
        // fold the new average into the period
        delay_sum_q      <= sum_sat;
        sample_counter_q <= cnt_inc;
        if (avg_q > largest_q) begin
          largest_q <= avg_q;
        end
        if (avg_q < smallest_q) begin
          smallest_q <= avg_q;
        end
      end
      if (state_q == hcrt_pkg::ST_STEP) begin
        // take the step, remember the total, open a fresh period
        level_q          <= level_next;
        dir_up_q         <= dir_next;
        previous_sum_q   <= trimmed_q;
        sample_counter_q <= '0;
        delay_sum_q      <= '0;
        largest_q        <= '0;
        smallest_q       <= '1;
      end
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      avg_q     <= '0;
      updated_q <= 1'b0;
    end
    if (state_q == hcrt_pkg::ST_DIV && div_done) begin
      avg_q <= quotient;
    end
    if (state_q == hcrt_pkg::ST_TRIM) begin
      // drop the extremes, saturating at zero
      trimmed_q <= (delay_sum_q > cut) ? delay_sum_q - cut : '0;
      step_q    <= (lvl10 > LW'(1)) ? lvl10 : LW'(1);
    end
    if (state_q == hcrt_pkg::ST_STEP) begin
      updated_q <= 1'b1;
    end
  end

  // output register: hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_level_q   <= level_q;
      out_updated_q <= updated_q;
      out_avg_q     <= avg_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pause_level_o   = out_level_q;
  assign level_updated_o = out_updated_q;
  assign average_delay_o = out_avg_q;

  // a control step never leaves the level above the clamp
  a_level_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hcrt_pkg::ST_STEP |=> level_q <= max_level_q)
    else $error("level above max_level after a control step");

  // the divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == hcrt_pkg::ST_DIV)
    else $error("divider done outside the divide state");

  // a fresh result appears only from the output state
  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == hcrt_pkg::ST_OUT)
    else $error("result raised outside the output state");

  // a control step clears the period accumulators
  a_period_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hcrt_pkg::ST_STEP |=> sample_counter_q == '0 && delay_sum_q == '0)
    else $error("period not cleared after a control step");

endmodule

`default_nettype wire

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcrt_pkg::*;

  // Widths follow the default build of the tuner.
  localparam int DW = DELAY_BITS_DEF;
  localparam int SW = DW + 8;

  // Cycles without any accepted transaction before the run is declared hung.
  // The slowest legal stretch is the receiver's long hold plus one divide.
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 228;

  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [DW-1:0]         delay_t;
  typedef logic [SW-1:0]         sum_t;
  typedef logic [SW:0]           wide_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  localparam count_t COUNT_MAX = '1;
  localparam delay_t DELAY_MAX = '1;
  localparam sum_t   SUM_MAX   = '1;

  typedef struct packed {
    level_t lvl;
    logic   upd;
    delay_t avg;
  } tuner_result_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_e;

  // One row of the directed plan: either a register write or a sample, the
  // latter optionally carrying a hand-typed expected result.
  typedef struct {
    row_kind_e     kind;
    cfg_reg_e      reg_idx;
    cfg_word_t     value;
    count_t        count;
    delay_t        delay;
    bit            typed;
    tuner_result_t want;
  } plan_row_t;

  logic      clk;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  cfg_reg_e  cfg_index_i;
  cfg_word_t cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  count_t    commit_count_i;
  delay_t    commit_total_delay_i;
  logic      out_valid_o;
  logic      out_stall_i;
  level_t    pause_level_o;
  logic      level_updated_o;
  delay_t    average_delay_o;

  hill_climb_rate_tuner_top dut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .commit_count_i      (commit_count_i),
    .commit_total_delay_i(commit_total_delay_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .pause_level_o       (pause_level_o),
    .level_updated_o     (level_updated_o),
    .average_delay_o     (average_delay_o)
  );

  // Free-running 4 ns clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the tuner: registers and control state.
  // ---------------------------------------------------------------------------
  level_t          cfg_init_level;
  level_t          cfg_max_level;
  logic [7:0]      cfg_period;
  logic [7:0]      samples_taken;
  sum_t            delay_total;
  delay_t          peak_avg;
  delay_t          floor_avg;
  sum_t            last_trimmed;
  level_t          tuned_level;
  bit              heading_up;

  tuner_result_t   pending_results[$];
  plan_row_t       directed_plan[$];

  int              fail_count   = 0;
  bit              idle_on      = 1'b1;
  bit              hold_request = 1'b0;
  count_t          last_count   = 1;
  delay_t          last_delay   = '0;

  function automatic void clear_period();
    samples_taken = '0;
    delay_total   = '0;
    peak_avg      = '0;
    floor_avg     = DELAY_MAX;
  endfunction

  function automatic void load_register(cfg_reg_e idx, cfg_word_t value);
    case (idx)
      REG_INITIAL_LEVEL: begin
        // The live level follows the initial level at once.
        cfg_init_level = value;
        tuned_level    = value;
      end
      REG_MAX_LEVEL:      cfg_max_level = value;
      REG_CONTROL_PERIOD: cfg_period    = value[PERIOD_W-1:0];
      default: ;
    endcase
  endfunction

  // Accumulate one sample and, at the end of a control period, take one
  // perturb-and-observe step on the pause level.
  function automatic tuner_result_t predict_sample(count_t cnt, delay_t tot);
    tuner_result_t r;
    delay_t        avg;
    wide_t         cut;
    sum_t          trimmed;
    int            lvl;
    int            stride;
    int            moved;
    avg   = '0;
    r.upd = 1'b0;
    if (cnt != '0) begin
      avg = tot / delay_t'(cnt);
      if (delay_total > SUM_MAX - sum_t'(avg)) begin
        delay_total = SUM_MAX;
      end else begin
        delay_total = delay_total + sum_t'(avg);
      end
      if (avg > peak_avg) peak_avg = avg;
      if (avg < floor_avg) floor_avg = avg;
      samples_taken = samples_taken + 8'd1;
      if (samples_taken >= cfg_period || samples_taken == 8'd0) begin
        cut     = wide_t'(peak_avg) + wide_t'(floor_avg);
        trimmed = (wide_t'(delay_total) > cut) ? sum_t'(wide_t'(delay_total) - cut) : '0;
        lvl     = int'(tuned_level);
        stride  = lvl / 10;
        if (stride < 1) stride = 1;
        if (trimmed > last_trimmed) begin
          heading_up = !heading_up;
        end else if (trimmed == last_trimmed) begin
          stride = 0;
        end
        last_trimmed = trimmed;
        moved = heading_up ? lvl + stride : lvl - stride;
        if (moved < 0) moved = 0;
        if (moved > int'(cfg_max_level)) moved = int'(cfg_max_level);
        tuned_level = level_t'(moved);
        r.upd = 1'b1;
        clear_period();
      end
    end
    r.lvl = tuned_level;
    r.avg = avg;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan builders.
  // ---------------------------------------------------------------------------
  task automatic add_write(cfg_reg_e idx, cfg_word_t value);
    plan_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.value   = value;
    row.typed   = 1'b0;
    directed_plan.push_back(row);
  endtask

  task automatic add_sample(count_t cnt, delay_t tot);
    plan_row_t row;
    row.kind  = ROW_SAMPLE;
    row.count = cnt;
    row.delay = tot;
    row.typed = 1'b0;
    directed_plan.push_back(row);
  endtask

  task automatic add_checked(count_t cnt, delay_t tot, level_t lvl, logic upd, delay_t avg);
    plan_row_t row;
    row.kind  = ROW_SAMPLE;
    row.count = cnt;
    row.delay = tot;
    row.typed = 1'b1;
    row.want  = '{lvl: lvl, upd: upd, avg: avg};
    directed_plan.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; handshakes are sampled on the
  // rising edge, before the block updates its own outputs.
  // ---------------------------------------------------------------------------

  // Offer one sample transaction, optionally after a short gap, and record
  // its expected result once the block takes it.
  task automatic offer_sample(count_t cnt, delay_t tot, bit typed, tuner_result_t want);
    tuner_result_t r;
    int            gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i           <= 1'b1;
    commit_count_i       <= cnt;
    commit_total_delay_i <= tot;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    r = predict_sample(cnt, tot);
    pending_results.push_back(typed ? want : r);
  endtask

  // Write one register, but only once the block has gone quiet: drop the
  // sample channel, drain every outstanding result, then let it settle.
  task automatic set_register(cfg_reg_e idx, cfg_word_t value);
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    load_register(idx, value);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // Pick a random sample: mostly ordinary traffic with small counts, mixed
  // with zero counts, extreme fields, full-width noise and repeats of the
  // previous sample so that unchanged trimmed totals show up.
  task automatic pick_sample(output count_t cnt, output delay_t tot);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      cnt = '0;
      tot = delay_t'({$urandom, $urandom});
    end else if (mode < 12) begin
      cnt = 1;
      tot = ($urandom_range(0, 1) == 1) ? DELAY_MAX : delay_t'({$urandom, $urandom});
    end else if (mode < 16) begin
      cnt = COUNT_MAX;
      tot = delay_t'({$urandom, $urandom});
    end else if (mode < 24) begin
      cnt = last_count;
      tot = last_delay;
    end else if (mode < 44) begin
      cnt = count_t'($urandom);
      tot = delay_t'({$urandom, $urandom});
    end else begin
      cnt = count_t'($urandom_range(1, 64));
      tot = delay_t'($urandom_range(0, 1 << 20));
    end
    last_count = cnt;
    last_delay = tot;
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, plus one long hold on request so
  // that the output register fills and the block back-pressures its input.
  // The hold is counted here, independent of the sender.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end else if (hold_request) begin
        stall_left   = LONG_HOLD;
        hold_request = 1'b0;
      end else if (idle_on && rst_ni && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    tuner_result_t want;
    bit            bad;
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, level %0d updated %0d avg %0d",
                 $time, pause_level_o, level_updated_o, average_delay_o);
        fail_count = fail_count + 1;
      end else begin
        want = pending_results.pop_front();
        bad  = 1'b0;
        if (pause_level_o !== want.lvl) begin
          $display("%0t: pause_level expected %0d actual %0d", $time, want.lvl, pause_level_o);
          bad = 1'b1;
        end
        if (level_updated_o !== want.upd) begin
          $display("%0t: level_updated expected %0d actual %0d",
                   $time, want.upd, level_updated_o);
          bad = 1'b1;
        end
        if (average_delay_o !== want.avg) begin
          $display("%0t: average_delay expected %0d actual %0d",
                   $time, want.avg, average_delay_o);
          bad = 1'b1;
        end
        if (bad) fail_count = fail_count + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles in which no transaction moves on any channel.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_ni !== 1'b1 || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed plan, then random phases under varied settings.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    count_t cnt;
    delay_t tot;

    // Hold every input at a known value from time zero.
    rst_ni               <= 1'b0;
    in_valid_i           <= 1'b0;
    commit_count_i       <= '0;
    commit_total_delay_i <= '0;
    cfg_valid_i          <= 1'b0;
    cfg_index_i          <= REG_INITIAL_LEVEL;
    cfg_data_i           <= '0;

    // Shadow state after reset.
    cfg_init_level = INIT_LEVEL_RST;
    cfg_max_level  = MAX_LEVEL_RST;
    cfg_period     = PERIOD_RST;
    clear_period();
    last_trimmed   = SUM_MAX;
    tuned_level    = INIT_LEVEL_RST;
    heading_up     = 1'b1;

    // Zero count right after reset, then the field extremes.
    add_checked(0, DELAY_MAX, 16'd5, 1'b0, '0);
    add_checked(1, DELAY_MAX, 16'd5, 1'b0, DELAY_MAX);
    add_checked(COUNT_MAX, '0, 16'd5, 1'b0, '0);
    add_sample(COUNT_MAX, DELAY_MAX);
    add_sample(3, 1000);
    add_sample(1, 10);
    // One-sample period: the trimmed total goes below zero and saturates.
    add_write(REG_CONTROL_PERIOD, 1);
    add_sample(2, 50);
    // Period of zero: every nonzero sample closes a period.
    add_write(REG_CONTROL_PERIOD, 0);
    add_sample(4, 4);
    add_write(REG_CONTROL_PERIOD, 2);
    add_sample(1, 100);
    add_sample(1, 300);
    // Initial level loads the live level and sits above the clamp until the
    // next decision pulls it down.
    add_write(REG_MAX_LEVEL, 100);
    add_write(REG_INITIAL_LEVEL, 16'hFFFF);
    add_checked(0, 123, 16'hFFFF, 1'b0, '0);
    add_write(REG_CONTROL_PERIOD, 3);
    add_checked(1, 40, 16'hFFFF, 1'b0, 40);
    add_checked(1, 40, 16'hFFFF, 1'b0, 40);
    add_checked(1, 40, 16'd100, 1'b1, 40);
    // Same trimmed total again: no step.
    add_checked(1, 40, 16'd100, 1'b0, 40);
    add_checked(1, 40, 16'd100, 1'b0, 40);
    add_checked(1, 40, 16'd100, 1'b1, 40);
    // A clamp of zero pins the level at zero.
    add_write(REG_MAX_LEVEL, 0);
    add_checked(2, 14, 16'd100, 1'b0, 7);
    add_checked(2, 14, 16'd100, 1'b0, 7);
    add_checked(1, 7, 16'd0, 1'b1, 7);
    // Lower the period below the samples already taken.
    add_write(REG_CONTROL_PERIOD, 10);
    add_sample(5, 5000);
    add_sample(7, 123456);
    add_sample(1, 0);
    add_sample(9, 999999);
    add_write(REG_CONTROL_PERIOD, 3);
    add_sample(1, 1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Walk the directed plan.
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        set_register(directed_plan[i].reg_idx, directed_plan[i].value);
      end else begin
        offer_sample(directed_plan[i].count, directed_plan[i].delay,
                     directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases. Each starts from an idle block with fresh settings;
    // one middle phase and the final one run without any idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          set_register(REG_CONTROL_PERIOD, 3);
          set_register(REG_MAX_LEVEL, 16'hFFFF);
          set_register(REG_INITIAL_LEVEL, 0);
        end
        1: begin
          set_register(REG_CONTROL_PERIOD, 255);
          set_register(REG_MAX_LEVEL, 1);
          set_register(REG_INITIAL_LEVEL, 16'hFFFF);
        end
        2: begin
          set_register(REG_CONTROL_PERIOD, 4);
          set_register(REG_MAX_LEVEL, 16'hFFFF);
          set_register(REG_INITIAL_LEVEL, 1000);
        end
        3: begin
          set_register(REG_CONTROL_PERIOD, 1);
          set_register(REG_MAX_LEVEL, 0);
          set_register(REG_INITIAL_LEVEL, 30);
        end
        4: begin
          set_register(REG_CONTROL_PERIOD, 0);
          set_register(REG_MAX_LEVEL, 300);
          set_register(REG_INITIAL_LEVEL, 200);
        end
        5: begin
          set_register(REG_CONTROL_PERIOD, 2);
          set_register(REG_MAX_LEVEL, 50);
          set_register(REG_INITIAL_LEVEL, 12);
        end
        6: begin
          set_register(REG_CONTROL_PERIOD, cfg_word_t'($urandom_range(3, 12)));
          set_register(REG_MAX_LEVEL, cfg_word_t'($urandom_range(1, 65535)));
          set_register(REG_INITIAL_LEVEL, cfg_word_t'($urandom_range(0, 65535)));
        end
        default: begin
          set_register(REG_CONTROL_PERIOD, PERIOD_RST);
          set_register(REG_MAX_LEVEL, MAX_LEVEL_RST);
          set_register(REG_INITIAL_LEVEL, INIT_LEVEL_RST);
        end
      endcase
      idle_on = (phase != 3 && phase != PHASES - 1);
      for (int item = 0; item < PHASE_ITEMS; item++) begin
        // Ask the receiver for its long hold once, early in the run.
        if (phase == 0 && item == 60) hold_request = 1'b1;
        pick_sample(cnt, tot);
        offer_sample(cnt, tot, 1'b0, '0);
      end
    end

    // Drop the sample channel, drain the remaining results, then let the
    // block sit for a while to catch any stray output.
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: hill_climb_rate_tuner_top.f
design/hcrt_pkg.sv
design/hcrt_divider.sv
design/hill_climb_rate_tuner_top.sv
verif/tb.sv
